// ----- rtl/hic_pkg.sv -----
// shared types, constants and transform helpers for the hilbert index codec
`timescale 1ns / 1ps

package hic_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int MAX_BITS  = 16;
  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 64;
  localparam int DIMS_W    = 3;
  localparam int BITS_W    = 5;
  localparam int LVL_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS = 2'd1;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [DIMS_W-1:0] n;
    logic [BITS_W-1:0] bits;
  } hic_cfg_t;

  typedef struct packed {
    logic                                valid;
    logic                                mode;
    logic [MAX_DIMS-1:0]                 e;
    logic [1:0]                          d;
    logic [INDEX_W-1:0]                  h;
    logic [MAX_DIMS-1:0][COORD_W-1:0]    pt;
    logic [MAX_DIMS-1:0][COORD_W-1:0]    coord;
    logic [INDEX_W-1:0]                  idx;
  } hic_stage_t;

  function automatic logic [MAX_DIMS-1:0] word_mask(input logic [DIMS_W-1:0] n);
    logic [MAX_DIMS-1:0] m;
    case (n)
      3'd2:    m = 4'h3;
      3'd3:    m = 4'h7;
      default: m = 4'hf;
    endcase
    return m;
  endfunction

  // reduce a value below 8 modulo n, n in 2..4
  function automatic logic [1:0] mod_small(input logic [2:0] v, input logic [DIMS_W-1:0] n);
    logic [2:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= n) r = r - n;
    end
    return r[1:0];
  endfunction

  function automatic logic [MAX_DIMS-1:0] rot_right(input logic [MAX_DIMS-1:0] a,
                                                     input logic [2:0] k,
                                                     input logic [DIMS_W-1:0] n);
    logic [MAX_DIMS-1:0] res;
    logic [1:0]          r;
    logic [2:0]          ix;
    res = '0;
    r   = mod_small(k, n);
    for (int i = 0; i < MAX_DIMS; i++) begin
      ix = 3'(i) + {1'b0, r};
      if (ix >= n) ix = ix - n;
      if (3'(i) < n) res[i] = a[ix[1:0]];
    end
    return res;
  endfunction

  function automatic logic [MAX_DIMS-1:0] rot_left(input logic [MAX_DIMS-1:0] a,
                                                    input logic [2:0] k,
                                                    input logic [DIMS_W-1:0] n);
    logic [1:0] r;
    logic [2:0] kk;
    r  = mod_small(k, n);
    kk = (r == 2'd0) ? 3'd0 : (n - {1'b0, r});
    return rot_right(a, kk, n);
  endfunction

  function automatic logic [MAX_DIMS-1:0] gray(input logic [MAX_DIMS-1:0] a);
    return a ^ (a >> 1);
  endfunction

  function automatic logic [MAX_DIMS-1:0] gray_inv(input logic [MAX_DIMS-1:0] a,
                                                    input logic [DIMS_W-1:0] n);
    return (a ^ (a >> 1) ^ (a >> 2) ^ (a >> 3)) & word_mask(n);
  endfunction

  function automatic logic [2:0] trailing_ones(input logic [MAX_DIMS-1:0] a);
    logic [2:0] c;
    if (!a[0])      c = 3'd0;
    else if (!a[1]) c = 3'd1;
    else if (!a[2]) c = 3'd2;
    else if (!a[3]) c = 3'd3;
    else            c = 3'd4;
    return c;
  endfunction

  function automatic logic [MAX_DIMS-1:0] entry_of(input logic [MAX_DIMS-1:0] w,
                                                    input logic [DIMS_W-1:0] n);
    logic [MAX_DIMS-1:0] wm;
    wm    = w - 4'd1;
    wm[0] = 1'b0;
    return (w == '0) ? '0 : (gray(wm) & word_mask(n));
  endfunction

  function automatic logic [1:0] dir_of(input logic [MAX_DIMS-1:0] w,
                                        input logic [DIMS_W-1:0] n);
    logic [1:0] r;
    if (w == '0)      r = 2'd0;
    else if (!w[0])   r = mod_small(trailing_ones(w - 4'd1), n);
    else              r = mod_small(trailing_ones(w), n);
    return r;
  endfunction

endpackage

// ----- rtl/hic_cell.sv -----
// one bit level of the hilbert walk: transform, gray step and entry/direction update
`timescale 1ns / 1ps

module hic_cell
  import hic_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  hic_cfg_t         cfg_i,
  input  logic [LVL_W-1:0] lvl_i,
  input  hic_stage_t       stage_i,
  output hic_stage_t       stage_o
);

  hic_stage_t          stage_r;
  hic_stage_t          stage_nxt;
  logic                active;
  logic [2:0]          d1;
  logic [MAX_DIMS-1:0] lbits;
  logic [MAX_DIMS-1:0] enc_w;
  logic [MAX_DIMS-1:0] dec_w;
  logic [MAX_DIMS-1:0] w;
  logic [MAX_DIMS-1:0] dec_l;
  logic [5:0]          pos;
  logic [INDEX_W-1:0]  idx_sh;

  always_comb begin
    stage_nxt = stage_i;
    active    = ({1'b0, lvl_i} < cfg_i.bits);
    d1        = {1'b0, stage_i.d} + 3'd1;

    for (int j = 0; j < MAX_DIMS; j++) begin
      lbits[j] = (3'(j) < cfg_i.n) ? stage_i.coord[j][lvl_i] : 1'b0;
    end
    enc_w = gray_inv(rot_right(lbits ^ stage_i.e, d1, cfg_i.n), cfg_i.n);

    pos    = 6'({2'b00, lvl_i} * {3'b000, cfg_i.n});
    idx_sh = stage_i.idx >> pos;
    dec_w  = idx_sh[MAX_DIMS-1:0] & word_mask(cfg_i.n);

    w     = (stage_i.mode == MODE_DECODE) ? dec_w : enc_w;
    dec_l = rot_left(gray(w), d1, cfg_i.n) ^ stage_i.e;

    if (active) begin
      stage_nxt.e = stage_i.e ^ rot_left(entry_of(w, cfg_i.n), d1, cfg_i.n);
      stage_nxt.d = mod_small({1'b0, stage_i.d} + {1'b0, dir_of(w, cfg_i.n)} + 3'd1, cfg_i.n);
      if (stage_i.mode == MODE_ENCODE) begin
        case (cfg_i.n)
          3'd2:    stage_nxt.h = {stage_i.h[INDEX_W-3:0], w[1:0]};
          3'd3:    stage_nxt.h = {stage_i.h[INDEX_W-4:0], w[2:0]};
          default: stage_nxt.h = {stage_i.h[INDEX_W-5:0], w};
        endcase
      end else begin
        for (int j = 0; j < MAX_DIMS; j++) begin
          if (3'(j) < cfg_i.n) stage_nxt.pt[j][lvl_i] = dec_l[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ----- rtl/hilbert_index_codec.sv -----
// top level of the hilbert index codec: config registers, chain of level cells, result register
`timescale 1ns / 1ps
//
// converts a point of up to four 16-bit coordinates to its hilbert index
// (in_mode 0) or an index back to its point (in_mode 1)
// request channel: a request is taken at a rising edge with start high and
// busy low; busy is high only while rst_n is low, so one request per cycle
// result channel: out_valid is high for one cycle with out_index_out and
// out_point_0..3; the receiver cannot stall and needs none
// pipeline: the request is registered through one cell per bit level (16
// cells), then the result register; throughput: one request per cycle
// config: cfg_we writes cfg_data to register cfg_idx (0 num_dims,
// 1 num_bits) at the clock edge; other indexes are ignored; write only while
// no request is in flight
// reset: synchronous, active low; clears the pipeline valids and result
// strobe, num_dims returns to 3 and num_bits to 16
//
module hilbert_index_codec
  import hic_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_mode,
  input  logic [COORD_W-1:0]   in_coord_0,
  input  logic [COORD_W-1:0]   in_coord_1,
  input  logic [COORD_W-1:0]   in_coord_2,
  input  logic [COORD_W-1:0]   in_coord_3,
  input  logic [INDEX_W-1:0]   in_index_in,
  output logic                 out_valid,
  output logic [INDEX_W-1:0]   out_index_out,
  output logic [COORD_W-1:0]   out_point_0,
  output logic [COORD_W-1:0]   out_point_1,
  output logic [COORD_W-1:0]   out_point_2,
  output logic [COORD_W-1:0]   out_point_3
);

  logic [DIMS_W-1:0]                num_dims_r;
  logic [BITS_W-1:0]                num_bits_r;
  hic_cfg_t                         cfg;
  logic                             in_acc;
  hic_stage_t                       chain [MAX_BITS+1];
  hic_stage_t                       last;
  logic                             out_valid_r;
  logic [INDEX_W-1:0]               index_r;
  logic [MAX_DIMS-1:0][COORD_W-1:0] point_r;

  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r <= 3'd3;
      num_bits_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NUM_DIMS: num_dims_r <= cfg_data[DIMS_W-1:0];
        REG_NUM_BITS: num_bits_r <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported ranges
  always_comb begin
    if (num_dims_r < 3'd2)                  cfg.n = 3'd2;
    else if (num_dims_r > DIMS_W'(MAX_DIMS)) cfg.n = DIMS_W'(MAX_DIMS);
    else                                    cfg.n = num_dims_r;
    cfg.bits = (num_bits_r > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : num_bits_r;
  end

  always_comb begin
    chain[0].valid = in_acc;
    chain[0].mode  = in_mode;
    chain[0].e     = '0;
    chain[0].d     = 2'd1;
    chain[0].h     = '0;
    chain[0].pt    = '0;
    chain[0].coord = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};
    chain[0].idx   = in_index_in;
  end

  // cell k handles bit level MAX_BITS-1-k, top level first
  for (genvar k = 0; k < MAX_BITS; k++) begin : g_cell
    hic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cfg_i   (cfg),
      .lvl_i   (LVL_W'(MAX_BITS - 1 - k)),
      .stage_i (chain[k]),
      .stage_o (chain[k+1])
    );
  end

  assign last = chain[MAX_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= last.valid;
    end
    index_r <= (last.mode == MODE_ENCODE) ? last.h : '0;
    point_r <= (last.mode == MODE_DECODE) ? last.pt : '0;
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = index_r;
  assign out_point_0   = point_r[0];
  assign out_point_1   = point_r[1];
  assign out_point_2   = point_r[2];
  assign out_point_3   = point_r[3];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, MAX_BITS + 1))
    else $error("result without matching request");

  a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_out != '0) |->
      (out_point_0 == '0 && out_point_1 == '0 && out_point_2 == '0 && out_point_3 == '0))
    else $error("index and point both nonzero");

  a_unused_dim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg.n != DIMS_W'(MAX_DIMS)) |-> (out_point_3 == '0))
    else $error("unused coordinate nonzero");

endmodule
